// ===== src/epcs_pkg.sv =====
// Shared types and constants for the EEPROM page chunk sequencer.
// No dependencies; imported by epcs_ctrl and eeprom_page_chunk_sequencer.
`timescale 1ns / 1ps
`default_nettype none

package epcs_pkg;

  // Defaults for the top level parameters
  localparam int PAGE_SIZE_DEF  = 64;   // power of two, 2 to 256
  localparam int TIME_WIDTH_DEF = 32;   // 16 to 64

  // Fixed field widths
  localparam int ADDR_W   = 16;
  localparam int OFFS_W   = 15;
  localparam int CFG_W    = 16;
  localparam int ACTION_W = 3;

  // Configuration register indexes
  localparam logic REG_WRITE_DELAY  = 1'b0;
  localparam logic REG_ADDRESS_MASK = 1'b1;

  // Configuration reset values
  localparam logic [CFG_W-1:0] WRITE_DELAY_RST  = 16'd5000;
  localparam logic [CFG_W-1:0] ADDRESS_MASK_RST = 16'hFFFF;

  // Control and status part of one result beat
  typedef struct packed {
    logic [1:0] return_code;
    logic       issue_valid;
    logic       issue_write;
    logic [1:0] request_status;
    logic       busy_res;
  } epcs_status_t;

endpackage

`default_nettype wire

// ===== src/epcs_ctrl.sv =====
// Sequencer state, configuration registers and per-beat next-state logic.
// Depends on epcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module epcs_ctrl
  import epcs_pkg::*;
#(
  parameter int PAGE_SIZE  = PAGE_SIZE_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_data,
  input  wire logic                          accept,
  input  wire logic [ACTION_W-1:0]           action,
  input  wire logic [ADDR_W-1:0]             base_address,
  input  wire logic [ADDR_W-1:0]             total_length,
  input  wire logic                          bus_accepts,
  input  wire logic [1:0]                    bus_status,
  input  wire logic [TIME_WIDTH-1:0]         now_time,
  output epcs_status_t                       res,
  output logic [ADDR_W-1:0]                  issue_address,
  output logic [$clog2(PAGE_SIZE+1)-1:0]     issue_length,
  output logic [OFFS_W-1:0]                  buffer_word_offset
);

  localparam int LEN_W  = $clog2(PAGE_SIZE + 1);
  localparam int PAGE_B = $clog2(PAGE_SIZE);

  localparam logic [2:0] ST_IDLE        = 3'd0;
  localparam logic [2:0] ST_READ_START  = 3'd1;
  localparam logic [2:0] ST_READ_WAIT   = 3'd2;
  localparam logic [2:0] ST_WRITE_START = 3'd3;
  localparam logic [2:0] ST_WRITE_WAIT  = 3'd4;
  localparam logic [2:0] ST_WRITE_DELAY = 3'd5;
  localparam logic [2:0] ST_ERROR       = 3'd6;

  localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ABORT = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_INIT  = 3'd4;

  localparam logic [1:0] RC_OK      = 2'd0;
  localparam logic [1:0] RC_INVALID = 2'd1;
  localparam logic [1:0] RC_BUSY    = 2'd2;

  localparam logic [1:0] RS_IDLE     = 2'd0;
  localparam logic [1:0] RS_STARTED  = 2'd1;
  localparam logic [1:0] RS_DONE_OK  = 2'd2;
  localparam logic [1:0] RS_DONE_ERR = 2'd3;

  localparam logic [1:0] BS_DONE  = 2'd1;
  localparam logic [1:0] BS_ERROR = 2'd2;

  // Configuration
  logic [CFG_W-1:0] write_delay;
  logic [CFG_W-1:0] address_mask;

  // Sequencer state
  logic [2:0]            control_state,    control_state_next;
  logic                  request_active,   request_active_next;
  logic [ADDR_W-1:0]     current_address,  current_address_next;
  logic [ADDR_W-1:0]     remaining_length, remaining_length_next;
  logic [LEN_W-1:0]      chunk_length,     chunk_length_next;
  logic [OFFS_W-1:0]     word_offset,      word_offset_next;
  logic [TIME_WIDTH-1:0] ready_time,       ready_time_next;
  logic [1:0]            status_value,     status_value_next;

  // Chunk cutter operands and results
  logic [ADDR_W-1:0] adv_address;
  logic [OFFS_W-1:0] adv_offset;
  logic [ADDR_W-1:0] cut_address;
  logic [ADDR_W-1:0] cut_remaining;
  logic [LEN_W-1:0]  to_page_end;
  logic [LEN_W-1:0]  cut_part;
  logic [ADDR_W-1:0] cut_left;
  logic              cut_empty;

  logic [1:0] rc;
  logic       issue;
  logic       is_write;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_delay  <= WRITE_DELAY_RST;
      address_mask <= ADDRESS_MASK_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_WRITE_DELAY) begin
        write_delay <= cfg_data;
      end else begin
        address_mask <= cfg_data;
      end
    end
  end

  // Advance past the current chunk
  assign adv_address = current_address + ADDR_W'(chunk_length);
  assign adv_offset  = word_offset + OFFS_W'(chunk_length >> 1);

  // Cut the next chunk: up to the page end, at most what is left
  assign cut_address   = (control_state == ST_IDLE) ? base_address : adv_address;
  assign cut_remaining = (control_state == ST_IDLE) ? total_length : remaining_length;
  assign to_page_end   = LEN_W'(PAGE_SIZE) - LEN_W'(cut_address[PAGE_B-1:0]);
  assign cut_part      = (cut_remaining < ADDR_W'(to_page_end)) ?
                         cut_remaining[LEN_W-1:0] : to_page_end;
  assign cut_left      = cut_remaining - ADDR_W'(cut_part);
  assign cut_empty     = (cut_part == '0);

  // Next state and result for the beat on the input
  always_comb begin
    control_state_next    = control_state;
    request_active_next   = request_active;
    current_address_next  = current_address;
    remaining_length_next = remaining_length;
    chunk_length_next     = chunk_length;
    word_offset_next      = word_offset;
    ready_time_next       = ready_time;
    status_value_next     = status_value;
    rc                    = RC_OK;
    issue                 = 1'b0;
    is_write              = 1'b0;

    if (control_state != ST_IDLE && action == ACT_ABORT) begin
      request_active_next = 1'b0;
    end else if (control_state != ST_IDLE && action != ACT_TICK) begin
      rc = RC_INVALID;
    end else begin
      case (control_state)
        ST_IDLE: begin
          if (action == ACT_READ || action == ACT_WRITE) begin
            request_active_next   = 1'b1;
            status_value_next     = RS_STARTED;
            current_address_next  = base_address;
            remaining_length_next = cut_left;
            chunk_length_next     = cut_part;
            word_offset_next      = '0;
            if (cut_empty) begin
              status_value_next   = RS_DONE_OK;
              request_active_next = 1'b0;
            end else begin
              control_state_next = (action == ACT_READ) ? ST_READ_START : ST_WRITE_START;
            end
          end else if (action != ACT_INIT) begin
            rc = RC_INVALID;
          end
        end
        ST_READ_START, ST_WRITE_START: begin
          if (!request_active) begin
            control_state_next = ST_ERROR;
          end else begin
            issue    = 1'b1;
            is_write = (control_state == ST_WRITE_START);
            if (!bus_accepts) begin
              status_value_next = RS_IDLE;
              rc                = RC_BUSY;
            end else begin
              control_state_next = is_write ? ST_WRITE_WAIT : ST_READ_WAIT;
            end
          end
        end
        ST_WRITE_WAIT: begin
          if (bus_status == BS_DONE) begin
            ready_time_next    = now_time + TIME_WIDTH'(write_delay);
            control_state_next = ST_WRITE_DELAY;
          end else if (bus_status == BS_ERROR) begin
            control_state_next = ST_ERROR;
          end
        end
        ST_WRITE_DELAY, ST_READ_WAIT: begin
          if ((control_state == ST_WRITE_DELAY) ? (now_time > ready_time)
                                                : (bus_status == BS_DONE)) begin
            if (!request_active) begin
              control_state_next = ST_ERROR;
            end else begin
              current_address_next  = adv_address;
              word_offset_next      = adv_offset;
              remaining_length_next = cut_left;
              chunk_length_next     = cut_part;
              if (cut_empty) begin
                status_value_next   = RS_DONE_OK;
                request_active_next = 1'b0;
                control_state_next  = ST_IDLE;
              end else begin
                control_state_next = (control_state == ST_WRITE_DELAY) ?
                                     ST_WRITE_START : ST_READ_START;
              end
            end
          end else if (control_state == ST_READ_WAIT && bus_status == BS_ERROR) begin
            control_state_next = ST_ERROR;
          end
        end
        ST_ERROR: begin
          if (request_active) begin
            status_value_next = RS_DONE_ERR;
          end
          control_state_next = ST_IDLE;
        end
        default: begin
          control_state_next = ST_IDLE;
          rc                 = RC_INVALID;
        end
      endcase
    end
  end

  // Drive the result
  always_comb begin
    res.return_code    = rc;
    res.issue_valid    = issue;
    res.issue_write    = issue & is_write;
    res.request_status = status_value_next;
    res.busy_res       = (control_state_next != ST_IDLE);
    issue_address      = issue ? (current_address & address_mask) : '0;
    issue_length       = issue ? chunk_length : '0;
    buffer_word_offset = issue ? word_offset : '0;
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      control_state    <= ST_IDLE;
      request_active   <= 1'b0;
      current_address  <= '0;
      remaining_length <= '0;
      chunk_length     <= '0;
      word_offset      <= '0;
      ready_time       <= '0;
      status_value     <= RS_IDLE;
    end else if (accept) begin
      control_state    <= control_state_next;
      request_active   <= request_active_next;
      current_address  <= current_address_next;
      remaining_length <= remaining_length_next;
      chunk_length     <= chunk_length_next;
      word_offset      <= word_offset_next;
      ready_time       <= ready_time_next;
      status_value     <= status_value_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A pending chunk is never empty and never crosses a page boundary
  a_chunk_in_page: assert property (@(posedge clk) disable iff (rst)
    (control_state == ST_READ_START || control_state == ST_WRITE_START ||
     control_state == ST_READ_WAIT || control_state == ST_WRITE_WAIT)
    |-> (chunk_length != '0) &&
        ((LEN_W + 1)'(current_address[PAGE_B-1:0]) + (LEN_W + 1)'(chunk_length)
         <= (LEN_W + 1)'(PAGE_SIZE)))
    else $error("chunk length out of page");

  // A tick in the error state always returns to idle
  a_error_one_beat: assert property (@(posedge clk) disable iff (rst)
    (accept && control_state == ST_ERROR && action == ACT_TICK)
    |=> (control_state == ST_IDLE))
    else $error("error state did not return to idle");

  // Sequencer state only moves on an accepted beat
  a_hold_without_beat: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(control_state) && $stable(current_address) &&
                $stable(remaining_length) && $stable(word_offset))
    else $error("state changed without a beat");

  // A request drops only through a beat or reset
  a_active_drop: assert property (@(posedge clk)
    $fell(request_active) |-> ($past(accept) || $past(rst)))
    else $error("request dropped without a beat");

  // Issuing a command keeps the sequencer busy
  a_issue_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && res.issue_valid) |-> res.busy_res)
    else $error("command issued while going idle");
`endif

endmodule

`default_nettype wire

// ===== src/eeprom_page_chunk_sequencer.sv =====
// Top level of the EEPROM page chunk sequencer: stream ports and result register.
// Depends on epcs_pkg and epcs_ctrl.
//
//  Channel  Direction  Handshake          Payload (low bit up)
//  s_*      in         s_tvalid/s_tready  tuser: action; tdata: base_address,
//                                         total_length, bus_accepts, bus_status, now_time
//  m_*      out        m_tvalid/m_tready  tdata: return_code, issue_valid, issue_write,
//                                         issue_address, issue_length, buffer_word_offset,
//                                         request_status, busy_res
//  cfg_*    in         cfg_we             cfg_index selects register, cfg_data value
//
// One beat per cycle in both directions while the m side is not stalled; each input
// beat yields one result beat in the following cycle, set by the single result register after the state logic.
// Reset (rst, synchronous) clears the sequencer to idle, an empty result register
// and the register defaults; no clearing pass follows.
// A stalled m side holds the result; s_tready stays high while it is taken.
`timescale 1ns / 1ps
`default_nettype none

module eeprom_page_chunk_sequencer
  import epcs_pkg::*;
#(
  parameter int PAGE_SIZE  = PAGE_SIZE_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // Configuration write port
  input  wire logic                                    cfg_we,
  input  wire logic                                    cfg_index,
  input  wire logic [CFG_W-1:0]                        cfg_data,
  // Input stream
  input  wire logic                                    s_tvalid,
  output logic                                         s_tready,
  // tuser: action[2:0]
  input  wire logic [ACTION_W-1:0]                     s_tuser,
  // tdata: base_address[15:0], total_length[31:16], bus_accepts[32],
  //        bus_status[34:33], now_time[35 +: TIME_WIDTH], zero pad
  input  wire logic [((2*ADDR_W+3+TIME_WIDTH+7)/8)*8-1:0] s_tdata,
  // Result stream
  output logic                                         m_tvalid,
  input  wire logic                                    m_tready,
  // tdata: return_code[1:0], issue_valid[2], issue_write[3], issue_address[19:4],
  //        issue_length[20 +: LEN_W], buffer_word_offset, request_status,
  //        busy_res, zero pad
  output logic [((ADDR_W+OFFS_W+7+$clog2(PAGE_SIZE+1)+7)/8)*8-1:0] m_tdata
);

  localparam int LEN_W    = $clog2(PAGE_SIZE + 1);
  localparam int OUT_BITS = ADDR_W + OFFS_W + 7 + LEN_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int NOW_LSB  = 2 * ADDR_W + 3;

  logic accept;

  epcs_status_t      cur_status;
  logic [ADDR_W-1:0] cur_address;
  logic [LEN_W-1:0]  cur_length;
  logic [OFFS_W-1:0] cur_offset;

  // Result register
  epcs_status_t      out_status;
  logic [ADDR_W-1:0] out_address;
  logic [LEN_W-1:0]  out_length;
  logic [OFFS_W-1:0] out_offset;

  // Take a beat whenever the result register is free or being emptied
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  epcs_ctrl #(
    .PAGE_SIZE  (PAGE_SIZE),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .accept             (accept),
    .action             (s_tuser),
    .base_address       (s_tdata[ADDR_W-1:0]),
    .total_length       (s_tdata[2*ADDR_W-1:ADDR_W]),
    .bus_accepts        (s_tdata[2*ADDR_W]),
    .bus_status         (s_tdata[2*ADDR_W+2:2*ADDR_W+1]),
    .now_time           (s_tdata[NOW_LSB +: TIME_WIDTH]),
    .res                (cur_status),
    .issue_address      (cur_address),
    .issue_length       (cur_length),
    .buffer_word_offset (cur_offset)
  );

  // Hold valid until the result beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Load the result payload on each accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status  <= cur_status;
      out_address <= cur_address;
      out_length  <= cur_length;
      out_offset  <= cur_offset;
    end
  end

  // Pack the result beat
  assign m_tdata = OUT_W'({out_status.busy_res, out_status.request_status, out_offset,
                           out_length, out_address, out_status.issue_write,
                           out_status.issue_valid, out_status.return_code});

endmodule

`default_nettype wire
